>>> design/rcjc_pkg.sv
// ----------------------------------------------------------------------------
// rcjc_pkg
// shared types, sizes and codes of the coverage and junction counter
// ----------------------------------------------------------------------------
package rcjc_pkg;

    // storage sizes
    localparam int REGION_DEPTH  = 32768;
    localparam int MAX_EXONS     = 64;
    localparam int PAIR_ENTRIES  = 256;
    localparam int EXTRA_ENTRIES = 256;

    localparam int CAW = $clog2(REGION_DEPTH);
    localparam int EXW = $clog2(MAX_EXONS);
    localparam int PTW = $clog2(PAIR_ENTRIES);
    localparam int XTW = $clog2(EXTRA_ENTRIES);
    localparam int TIW = ((PTW > XTW) ? PTW : XTW) + 1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 32;
    localparam int CODE_W  = 4;
    localparam int LEN_W   = 28;
    localparam int SLOT_W  = 15;
    localparam int TLY_W   = 16;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = 8;
    localparam int EXC_W   = 7;
    localparam int CIDX_W  = 2;

    // junction match window
    localparam logic [POS_W-1:0] JWINDOW = 32'd10;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_CIGAR  = 3'd1,
        OP_RCOV   = 3'd2,
        OP_RPAIR  = 3'd3,
        OP_REXTRA = 3'd4
    } t_op;

    // cigar codes
    localparam logic [CODE_W-1:0] CIG_M    = 4'd0;
    localparam logic [CODE_W-1:0] CIG_I    = 4'd1;
    localparam logic [CODE_W-1:0] CIG_N    = 4'd3;
    localparam logic [CODE_W-1:0] CIG_S    = 4'd4;
    localparam logic [CODE_W-1:0] CIG_X    = 4'd8;
    localparam logic [CODE_W-1:0] CIG_LAST = 4'd8;

    // junction kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXTRA = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_REGION_END   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EXON_COUNT   = 2'd2;

    typedef enum logic [2:0] {
        CK_NONE,
        CK_LOAD,
        CK_COVER,
        CK_JUNC,
        CK_RCOV,
        CK_RPAIR,
        CK_REXTRA
    } t_ckind;

    typedef struct packed {
        t_ckind              kind;
        logic [POS_W-1:0]    pos;
        logic [LEN_W-1:0]    len;
        logic [SLOT_W-1:0]   slot;
        logic [POS_W-1:0]    blo;
        logic [POS_W-1:0]    bhi;
    } t_cmd;

    typedef struct packed {
        logic [TLY_W-1:0]    tally;
        logic [POS_W-1:0]    end_one;
        logic [POS_W-1:0]    end_two;
        logic [KIND_W-1:0]   kind;
        logic [ENTRY_W-1:0]  entry;
        logic                valid;
    } t_res;

    typedef struct packed {
        logic [POS_W-1:0]    region_start;
        logic [POS_W-1:0]    region_end;
        logic [EXC_W-1:0]    exon_count;
    } t_cfg;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_LOAD,
        B_CSET,
        B_CSET2,
        B_CRUN,
        B_JSET,
        B_EXRD,
        B_EXCMP,
        B_TBRD,
        B_TBCMP,
        B_TNEW,
        B_RDRD,
        B_RDOUT,
        B_OUT
    } t_bstate;

endpackage

>>> design/rcjc_front.sv
// ----------------------------------------------------------------------------
// rcjc_front
// accepts items, keeps the read offset and classifies items into commands
// ----------------------------------------------------------------------------
module rcjc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [rcjc_pkg::OP_W-1:0]     i_op,
    input  logic [rcjc_pkg::POS_W-1:0]    i_read_start,
    input  logic [rcjc_pkg::CODE_W-1:0]   i_cigar_code,
    input  logic [rcjc_pkg::LEN_W-1:0]    i_run_length,
    input  logic                          i_first_of_read,
    input  logic [rcjc_pkg::SLOT_W-1:0]   i_slot,
    input  logic [rcjc_pkg::POS_W-1:0]    i_bound_low,
    input  logic [rcjc_pkg::POS_W-1:0]    i_bound_high,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_full,
    output logic                          o_q_push,
    output rcjc_pkg::t_cmd                o_cmd
);
    import rcjc_pkg::*;

    logic [POS_W-1:0] r_offset, n_offset;
    logic [POS_W-1:0] base_off;
    logic             accept;
    logic             known;
    logic             advance;

    always_comb begin
        o_full   = i_q_full || i_clearing;
        accept   = i_push && !o_full;
        o_q_push = accept;
        base_off = i_first_of_read ? '0 : r_offset;
        known    = (i_cigar_code <= CIG_LAST);
        advance  = known && (i_cigar_code != CIG_I) && (i_cigar_code != CIG_S);

        n_offset = r_offset;
        if (accept && (i_op == OP_CIGAR)) begin
            n_offset = base_off + (advance ? POS_W'(i_run_length) : '0);
        end

        o_cmd.pos  = i_read_start + base_off;
        o_cmd.len  = i_run_length;
        o_cmd.slot = i_slot;
        o_cmd.blo  = i_bound_low;
        o_cmd.bhi  = i_bound_high;
        o_cmd.kind = CK_NONE;
        unique case (i_op)
            OP_LOAD: begin
                if (32'(i_slot) < 32'(MAX_EXONS)) o_cmd.kind = CK_LOAD;
            end
            OP_CIGAR: begin
                if (i_cigar_code == CIG_M || i_cigar_code == CIG_X) begin
                    o_cmd.kind = CK_COVER;
                end else if (i_cigar_code == CIG_N) begin
                    o_cmd.kind = CK_JUNC;
                end
            end
            OP_RCOV:   o_cmd.kind = CK_RCOV;
            OP_RPAIR:  o_cmd.kind = CK_RPAIR;
            OP_REXTRA: o_cmd.kind = CK_REXTRA;
            default:   o_cmd.kind = CK_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

>>> design/rcjc_fifo.sv
// ----------------------------------------------------------------------------
// rcjc_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module rcjc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcjc_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output rcjc_pkg::t_cmd  o_data,
    output logic            o_empty
);
    import rcjc_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    always_comb begin
        o_full  = (r_cnt == (QAW+1)'(QDEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == QAW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == QAW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

>>> design/rcjc_back.sv
// ----------------------------------------------------------------------------
// rcjc_back
// sequencer that carries out commands over the coverage and junction tables
// ----------------------------------------------------------------------------
module rcjc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcjc_pkg::t_cfg  i_cfg,
    input  logic            i_q_empty,
    input  rcjc_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    output logic            o_clearing,
    input  logic            i_pop,
    output logic            o_empty,
    output rcjc_pkg::t_res  o_res
);
    import rcjc_pkg::*;

    t_bstate r_st, n_st;
    t_cmd    r_cmd, n_cmd;
    t_res    r_pend, n_pend, r_res, n_res;
    logic    r_res_v, n_res_v;

    logic [CAW-1:0]   r_ca, n_ca, r_chi, n_chi, r_span, n_span;
    logic [POS_W-1:0] r_off, n_off, r_p2, n_p2;
    logic             r_cnone, n_cnone;
    logic             r_wb_v, n_wb_v;
    logic [CAW-1:0]   r_wb_a, n_wb_a;
    logic [EXW:0]     r_ei, n_ei;
    logic             r_e1v, n_e1v, r_e2v, n_e2v;
    logic [EXW-1:0]   r_e1, n_e1, r_e2, n_e2;
    logic [TIW-1:0]   r_ti, n_ti;
    logic [PTW:0]     r_pused, n_pused;
    logic [XTW:0]     r_xused, n_xused;

    // memories
    logic [TLY_W-1:0]   r_cov_mem [REGION_DEPTH];
    logic [TLY_W-1:0]   r_cov_q;
    logic [POS_W-1:0]   r_exlo_mem [MAX_EXONS];
    logic [POS_W-1:0]   r_exhi_mem [MAX_EXONS];
    logic [POS_W-1:0]   r_exlo_q, r_exhi_q;
    logic [2*EXW-1:0]   r_pnode_mem [PAIR_ENTRIES];
    logic [2*EXW-1:0]   r_pnode_q;
    logic [TLY_W-1:0]   r_ptly_mem [PAIR_ENTRIES];
    logic [TLY_W-1:0]   r_ptly_q;
    logic [POS_W-1:0]   r_xfst_mem [EXTRA_ENTRIES];
    logic [POS_W-1:0]   r_xsnd_mem [EXTRA_ENTRIES];
    logic [TLY_W-1:0]   r_xtly_mem [EXTRA_ENTRIES];
    logic [POS_W-1:0]   r_xfst_q, r_xsnd_q;
    logic [TLY_W-1:0]   r_xtly_q;

    logic             cov_we;
    logic [CAW-1:0]   cov_wa, cov_ra;
    logic [TLY_W-1:0] cov_wd;
    logic             ex_we;
    logic [EXW-1:0]   ex_wa, ex_ra;
    logic             p_node_we, p_tly_we;
    logic [PTW-1:0]   p_wa, p_ra;
    logic [TLY_W-1:0] p_tly_wd;
    logic             x_ends_we, x_tly_we;
    logic [XTW-1:0]   x_wa, x_ra;
    logic [TLY_W-1:0] x_tly_wd;

    // decode helpers
    logic [EXW:0]     ex_lim;
    logic             is_pair;
    logic [TIW-1:0]   used_cur;
    logic             hit1, hit2, both_found;
    logic             tb_match;
    logic             cov_hit;
    logic [CAW-1:0]   cov_lo, cov_hi;
    logic [POS_W-1:0] len_w, span_w, cut, wrap_lo;
    logic             slot_cov_ok, slot_pair_ok, slot_extra_ok;

    function automatic logic near(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        logic [POS_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d < JWINDOW;
    endfunction

    always_comb begin
        ex_lim = (32'(i_cfg.exon_count) > 32'(MAX_EXONS)) ? (EXW+1)'(MAX_EXONS)
                                                          : (EXW+1)'(i_cfg.exon_count);
        is_pair  = r_e1v && r_e2v;
        used_cur = is_pair ? TIW'(r_pused) : TIW'(r_xused);

        hit1 = (r_cmd.pos >= r_exlo_q) && (r_cmd.pos <= r_exhi_q);
        hit2 = (r_p2 >= r_exlo_q) && (r_p2 <= r_exhi_q);
        both_found = (r_e1v || hit1) && (r_e2v || hit2);

        tb_match = is_pair ? (r_pnode_q == {r_e1, r_e2})
                           : (near(r_cmd.pos, r_xfst_q) && near(r_p2, r_xsnd_q));

        // covered index range inside the store, the element wraps at most once
        len_w   = POS_W'(r_cmd.len);
        span_w  = POS_W'(r_span);
        wrap_lo = '0 - r_off;
        cov_hit = 1'b0;
        cov_lo  = '0;
        cov_hi  = '0;
        cut     = '0;
        if (!r_cnone) begin
            if (r_off < len_w) begin
                cut     = len_w - 32'd1 - r_off;
                cov_hit = 1'b1;
                cov_lo  = '0;
                cov_hi  = (cut > span_w) ? r_span : CAW'(cut);
            end else if (r_off != '0 && wrap_lo <= span_w) begin
                cut     = wrap_lo + len_w - 32'd1;
                cov_hit = 1'b1;
                cov_lo  = CAW'(wrap_lo);
                cov_hi  = (cut > span_w) ? r_span : CAW'(cut);
            end
        end

        slot_cov_ok   = 32'(r_cmd.slot) < 32'(REGION_DEPTH);
        slot_pair_ok  = (32'(r_cmd.slot) < 32'(r_pused)) &&
                        (32'(r_cmd.slot) < 32'(PAIR_ENTRIES));
        slot_extra_ok = (32'(r_cmd.slot) < 32'(r_xused)) &&
                        (32'(r_cmd.slot) < 32'(EXTRA_ENTRIES));
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_CLEAR: if (r_ca == CAW'(REGION_DEPTH-1)) n_st = B_IDLE;
            B_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_cmd.kind) inside
                        CK_LOAD:                      n_st = B_LOAD;
                        CK_COVER:                     n_st = B_CSET;
                        CK_JUNC:                      n_st = B_JSET;
                        CK_RCOV, CK_RPAIR, CK_REXTRA: n_st = B_RDRD;
                        default:                      n_st = B_OUT;
                    endcase
                end
            end
            B_LOAD:  n_st = B_OUT;
            B_CSET:  n_st = B_CSET2;
            B_CSET2: n_st = cov_hit ? B_CRUN : B_OUT;
            B_CRUN:  if (r_ca == r_chi) n_st = B_OUT;
            B_JSET:  n_st = B_EXRD;
            B_EXRD:  n_st = (r_ei >= ex_lim) ? B_TBRD : B_EXCMP;
            B_EXCMP: n_st = both_found ? B_TBRD : B_EXRD;
            B_TBRD:  n_st = (r_ti >= used_cur) ? B_TNEW : B_TBCMP;
            B_TBCMP: n_st = tb_match ? B_OUT : B_TBRD;
            B_TNEW:  n_st = B_OUT;
            B_RDRD:  n_st = B_RDOUT;
            B_RDOUT: n_st = B_OUT;
            B_OUT:   if (!r_res_v || i_pop) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd   = r_cmd;
        n_pend  = r_pend;
        n_res   = r_res;
        n_res_v = r_res_v && !i_pop;
        n_ca    = r_ca;
        n_chi   = r_chi;
        n_span  = r_span;
        n_off   = r_off;
        n_cnone = r_cnone;
        n_p2    = r_p2;
        n_wb_v  = 1'b0;
        n_wb_a  = r_wb_a;
        n_ei    = r_ei;
        n_e1v   = r_e1v;
        n_e2v   = r_e2v;
        n_e1    = r_e1;
        n_e2    = r_e2;
        n_ti    = r_ti;
        n_pused = r_pused;
        n_xused = r_xused;

        o_q_pop    = 1'b0;
        o_clearing = (r_st == B_CLEAR);

        cov_we = r_wb_v;
        cov_wa = r_wb_a;
        cov_wd = r_cov_q + 1'b1;
        cov_ra = r_ca;
        ex_we  = 1'b0;
        ex_wa  = EXW'(r_cmd.slot);
        ex_ra  = r_ei[EXW-1:0];
        p_node_we = 1'b0;
        p_tly_we  = 1'b0;
        p_wa      = r_ti[PTW-1:0];
        p_ra      = r_ti[PTW-1:0];
        p_tly_wd  = r_ptly_q + 1'b1;
        x_ends_we = 1'b0;
        x_tly_we  = 1'b0;
        x_wa      = r_ti[XTW-1:0];
        x_ra      = r_ti[XTW-1:0];
        x_tly_wd  = r_xtly_q + 1'b1;

        unique case (r_st)
            B_CLEAR: begin
                cov_we = 1'b1;
                cov_wa = r_ca;
                cov_wd = '0;
                n_ca   = r_ca + 1'b1;
            end
            B_IDLE: begin
                o_q_pop = !i_q_empty;
                n_cmd   = i_q_cmd;
                n_pend  = '0;
            end
            B_LOAD: ex_we = 1'b1;
            B_CSET: begin
                n_off   = i_cfg.region_start - r_cmd.pos;
                n_cnone = (i_cfg.region_end < i_cfg.region_start) || (r_cmd.len == '0);
                n_span  = ((i_cfg.region_end - i_cfg.region_start) > 32'(REGION_DEPTH-1))
                          ? CAW'(REGION_DEPTH-1)
                          : CAW'(i_cfg.region_end - i_cfg.region_start);
            end
            B_CSET2: begin
                n_ca  = cov_lo;
                n_chi = cov_hi;
            end
            B_CRUN: begin
                // read one counter, write it back incremented next cycle
                cov_ra = r_ca;
                n_wb_v = 1'b1;
                n_wb_a = r_ca;
                n_ca   = r_ca + 1'b1;
            end
            B_JSET: begin
                n_p2  = r_cmd.pos + POS_W'(r_cmd.len);
                n_ei  = '0;
                n_e1v = 1'b0;
                n_e2v = 1'b0;
                n_e1  = '0;
                n_e2  = '0;
                n_ti  = '0;
            end
            B_EXRD: ex_ra = r_ei[EXW-1:0];
            B_EXCMP: begin
                if (!r_e1v && hit1) begin
                    n_e1v = 1'b1;
                    n_e1  = r_ei[EXW-1:0];
                end
                if (!r_e2v && hit2) begin
                    n_e2v = 1'b1;
                    n_e2  = r_ei[EXW-1:0];
                end
                n_ei = r_ei + 1'b1;
            end
            B_TBRD: begin
                p_ra = r_ti[PTW-1:0];
                x_ra = r_ti[XTW-1:0];
            end
            B_TBCMP: begin
                if (tb_match) begin
                    n_pend.entry = ENTRY_W'(r_ti);
                    n_pend.valid = 1'b1;
                    if (is_pair) begin
                        p_tly_we        = 1'b1;
                        n_pend.tally    = p_tly_wd;
                        n_pend.end_one  = POS_W'(r_e1);
                        n_pend.end_two  = POS_W'(r_e2);
                        n_pend.kind     = KIND_PAIR;
                    end else begin
                        x_tly_we        = 1'b1;
                        n_pend.tally    = x_tly_wd;
                        n_pend.end_one  = r_cmd.pos;
                        n_pend.end_two  = r_p2;
                        n_pend.kind     = KIND_EXTRA;
                    end
                end else begin
                    n_ti = r_ti + 1'b1;
                end
            end
            B_TNEW: begin
                if (is_pair) begin
                    n_pend.end_one = POS_W'(r_e1);
                    n_pend.end_two = POS_W'(r_e2);
                    if (32'(r_pused) >= 32'(PAIR_ENTRIES)) begin
                        n_pend.kind = KIND_DROP;
                    end else begin
                        p_node_we    = 1'b1;
                        p_tly_we     = 1'b1;
                        p_wa         = r_pused[PTW-1:0];
                        p_tly_wd     = TLY_W'(1);
                        n_pused      = r_pused + 1'b1;
                        n_pend.tally = TLY_W'(1);
                        n_pend.kind  = KIND_PAIR;
                        n_pend.entry = ENTRY_W'(r_pused);
                        n_pend.valid = 1'b1;
                    end
                end else begin
                    n_pend.end_one = r_cmd.pos;
                    n_pend.end_two = r_p2;
                    if (32'(r_xused) >= 32'(EXTRA_ENTRIES)) begin
                        n_pend.kind = KIND_DROP;
                    end else begin
                        x_ends_we    = 1'b1;
                        x_tly_we     = 1'b1;
                        x_wa         = r_xused[XTW-1:0];
                        x_tly_wd     = TLY_W'(1);
                        n_xused      = r_xused + 1'b1;
                        n_pend.tally = TLY_W'(1);
                        n_pend.kind  = KIND_EXTRA;
                        n_pend.entry = ENTRY_W'(r_xused);
                        n_pend.valid = 1'b1;
                    end
                end
            end
            B_RDRD: begin
                cov_ra = CAW'(r_cmd.slot);
                p_ra   = PTW'(r_cmd.slot);
                x_ra   = XTW'(r_cmd.slot);
            end
            B_RDOUT: begin
                if (r_cmd.kind == CK_RCOV) begin
                    if (slot_cov_ok) begin
                        n_pend.tally = r_cov_q;
                        n_pend.valid = 1'b1;
                    end else begin
                        n_pend.entry = ENTRY_W'(r_cmd.slot);
                    end
                end else if (r_cmd.kind == CK_RPAIR) begin
                    n_pend.entry = ENTRY_W'(r_cmd.slot);
                    if (slot_pair_ok) begin
                        n_pend.tally   = r_ptly_q;
                        n_pend.end_one = POS_W'(r_pnode_q[2*EXW-1:EXW]);
                        n_pend.end_two = POS_W'(r_pnode_q[EXW-1:0]);
                        n_pend.kind    = KIND_PAIR;
                        n_pend.valid   = 1'b1;
                    end
                end else begin
                    n_pend.entry = ENTRY_W'(r_cmd.slot);
                    if (slot_extra_ok) begin
                        n_pend.tally   = r_xtly_q;
                        n_pend.end_one = r_xfst_q;
                        n_pend.end_two = r_xsnd_q;
                        n_pend.kind    = KIND_EXTRA;
                        n_pend.valid   = 1'b1;
                    end
                end
            end
            B_OUT: begin
                if (!r_res_v || i_pop) begin
                    n_res   = r_pend;
                    n_res_v = 1'b1;
                end
            end
            default: ;
        endcase

        o_empty = !r_res_v;
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_CLEAR;
            r_ca    <= '0;
            r_res_v <= 1'b0;
            r_wb_v  <= 1'b0;
            r_pused <= '0;
            r_xused <= '0;
        end else begin
            r_st    <= n_st;
            r_ca    <= n_ca;
            r_res_v <= n_res_v;
            r_wb_v  <= n_wb_v;
            r_pused <= n_pused;
            r_xused <= n_xused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_pend  <= n_pend;
        r_res   <= n_res;
        r_chi   <= n_chi;
        r_span  <= n_span;
        r_off   <= n_off;
        r_cnone <= n_cnone;
        r_p2    <= n_p2;
        r_wb_a  <= n_wb_a;
        r_ei    <= n_ei;
        r_e1v   <= n_e1v;
        r_e2v   <= n_e2v;
        r_e1    <= n_e1;
        r_e2    <= n_e2;
        r_ti    <= n_ti;
    end

    always_ff @(posedge i_clk) begin
        if (cov_we) r_cov_mem[cov_wa] <= cov_wd;
        r_cov_q <= r_cov_mem[cov_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ex_we) begin
            r_exlo_mem[ex_wa] <= r_cmd.blo;
            r_exhi_mem[ex_wa] <= r_cmd.bhi;
        end
        r_exlo_q <= r_exlo_mem[ex_ra];
        r_exhi_q <= r_exhi_mem[ex_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_node_we) r_pnode_mem[p_wa] <= {r_e1, r_e2};
        if (p_tly_we)  r_ptly_mem[p_wa]  <= p_tly_wd;
        r_pnode_q <= r_pnode_mem[p_ra];
        r_ptly_q  <= r_ptly_mem[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (x_ends_we) begin
            r_xfst_mem[x_wa] <= r_cmd.pos;
            r_xsnd_mem[x_wa] <= r_p2;
        end
        if (x_tly_we) r_xtly_mem[x_wa] <= x_tly_wd;
        r_xfst_q <= r_xfst_mem[x_ra];
        r_xsnd_q <= r_xsnd_mem[x_ra];
        r_xtly_q <= r_xtly_mem[x_ra];
    end

endmodule

>>> design/read_coverage_junction_counter_core.sv
// ----------------------------------------------------------------------------
// read_coverage_junction_counter_core
// per-base coverage and splice junction counting over one gene region
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  items     in         push / full               op .. bound_high
//  results   out        empty / pop               tally .. entry_valid
//  config    in         i_cfg_we, no wait         i_cfg_idx, i_cfg_data
//
//  work: a coverage element steps through the bases covered inside the store,
//  a junction element scans the exons and then the table entries in turn;
//  the coverage memory, read and written back per base, sets the M/X rate
//  reset: a clearing pass zeroes the coverage store, full is high meanwhile;
//  configuration writes are taken at any time
//  stalls: a two-deep command queue and an output register let items enter
//  while a result waits to be popped
// ----------------------------------------------------------------------------
module read_coverage_junction_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          push,
    output logic                          full,
    input  logic [rcjc_pkg::OP_W-1:0]     i_op,
    input  logic [rcjc_pkg::POS_W-1:0]    i_read_start,
    input  logic [rcjc_pkg::CODE_W-1:0]   i_cigar_code,
    input  logic [rcjc_pkg::LEN_W-1:0]    i_run_length,
    input  logic                          i_first_of_read,
    input  logic [rcjc_pkg::SLOT_W-1:0]   i_slot,
    input  logic [rcjc_pkg::POS_W-1:0]    i_bound_low,
    input  logic [rcjc_pkg::POS_W-1:0]    i_bound_high,
    // result channel
    output logic                          empty,
    input  logic                          pop,
    output logic [rcjc_pkg::TLY_W-1:0]    o_tally,
    output logic [rcjc_pkg::POS_W-1:0]    o_end_one,
    output logic [rcjc_pkg::POS_W-1:0]    o_end_two,
    output logic [rcjc_pkg::KIND_W-1:0]   o_junction_kind,
    output logic [rcjc_pkg::ENTRY_W-1:0]  o_entry_number,
    output logic                          o_entry_valid,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rcjc_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [rcjc_pkg::POS_W-1:0]    i_cfg_data
);
    import rcjc_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd front_cmd, q_cmd;
    t_res res;
    logic q_push, q_full, q_pop, q_empty;
    logic clearing;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_START: n_cfg.region_start = i_cfg_data;
                CFG_REGION_END:   n_cfg.region_end   = i_cfg_data;
                CFG_EXON_COUNT:   n_cfg.exon_count   = i_cfg_data[EXC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: accept, track read offset, classify
    rcjc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_op            (i_op),
        .i_read_start    (i_read_start),
        .i_cigar_code    (i_cigar_code),
        .i_run_length    (i_run_length),
        .i_first_of_read (i_first_of_read),
        .i_slot          (i_slot),
        .i_bound_low     (i_bound_low),
        .i_bound_high    (i_bound_high),
        .i_q_full        (q_full),
        .i_clearing      (clearing),
        .o_full          (full),
        .o_q_push        (q_push),
        .o_cmd           (front_cmd)
    );

    // command queue
    rcjc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // back: table sequencer and result register
    rcjc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_tally         = res.tally;
    assign o_end_one       = res.end_one;
    assign o_end_two       = res.end_two;
    assign o_junction_kind = res.kind;
    assign o_entry_number  = res.entry;
    assign o_entry_valid   = res.valid;

endmodule

>>> design/rcjc_checker.sv
// ----------------------------------------------------------------------------
// rcjc_checker
// port-level checks on the result channel of the counter
// ----------------------------------------------------------------------------
module rcjc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [rcjc_pkg::TLY_W-1:0]    o_tally,
    input logic [rcjc_pkg::POS_W-1:0]    o_end_one,
    input logic [rcjc_pkg::KIND_W-1:0]   o_junction_kind,
    input logic                          o_entry_valid
);
    import rcjc_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_tally) && $stable(o_end_one)))
        else $error("waiting result changed");

    // a dropped junction carries no entry and no count
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_junction_kind == KIND_DROP) |-> (!o_entry_valid && o_tally == '0))
        else $error("dropped junction with entry");

    // a counted junction always names a live entry
    a_junc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_junction_kind == KIND_PAIR || o_junction_kind == KIND_EXTRA))
        |-> o_entry_valid)
        else $error("junction without entry");

    // results with no meaning carry a zero tally and a zero first end
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_junction_kind == KIND_NONE && !o_entry_valid)
        |-> (o_tally == '0 && o_end_one == '0))
        else $error("invalid result not zero");

endmodule

bind read_coverage_junction_counter_core rcjc_checker u_rcjc_checker (.*);
